@@ sv/sbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsa_pkg
// Types, codes and helpers shared by the slab slot allocator.
// ----------------------------------------------------------------------------
package sbsa_pkg;

	localparam int ADDR_BITS     = 48;
	localparam int SIZE_W        = 21;
	localparam int CNT_W         = 9;
	localparam int KIND_W        = 2;
	localparam int WORD_W        = 64;
	localparam int DEF_NUM_SLABS = 8;
	localparam int DEF_MAX_SLOTS = 256;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_ALLOC    = 2'd1;
	localparam logic [1:0] OP_FREE     = 2'd2;
	localparam logic [1:0] OP_REMOVE   = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_SLOT  = 3'd1;
	localparam logic [2:0] ST_UNKNOWN  = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_BAD_SLOT = 3'd4;

	typedef struct packed {
		logic [1:0]           operation;
		logic [ADDR_BITS-1:0] base_addr;
		logic [ADDR_BITS-1:0] slot_address;
		logic [SIZE_W-1:0]    slot_bytes;
		logic [CNT_W-1:0]     slot_total;
		logic [KIND_W-1:0]    alloc_kind;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] address;
		logic                 slab_now_empty;
	} rsp_t;

	function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] w);
		logic [5:0] b;
		b = 6'd63;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				b = 6'(i);
			end
		end
		return b;
	endfunction

endpackage

@@ sv/slab_bitmap_slot_allocator.sv @@
// Slab slot allocator. One request beat gives one response beat. A request
// is taken in idle, walks the slab table one entry per cycle while no
// candidate bitmap is being read, then passes a dispatch state and a done
// state. Allocate also reads a candidate's bitmap words, one word at a time
// in a read state and a check state, through the single bitmap RAM port, up
// to ceil(MAX_SLOTS/64) words per candidate, then forms the address in a
// multiply state and an add state. Free waits on the one-bit-per-cycle
// divider, then, if the slot is in range, reads and writes one bitmap word.
// Register writes ceil(MAX_SLOTS/64) bitmap words. A new request is taken
// only when the previous one has left its result in the response register.
// ----------------------------------------------------------------------------
// slab_bitmap_slot_allocator
// Slab table with free-slot bitmaps, sequenced over a shared RAM and a divider.
// ----------------------------------------------------------------------------
module slab_bitmap_slot_allocator #(
	parameter int NUM_SLABS = sbsa_pkg::DEF_NUM_SLABS,
	parameter int MAX_SLOTS = sbsa_pkg::DEF_MAX_SLOTS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sbsa_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sbsa_pkg::rsp_t rsp
);
	import sbsa_pkg::*;

	localparam int WORDS = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int EW    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int DEPTH = NUM_SLABS * WORDS;
	localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(MAX_SLOTS);
	localparam int PW    = IW + SIZE_W;

	localparam logic [EW-1:0] LAST_K = EW'(NUM_SLABS - 1);
	localparam logic [WW-1:0] LAST_W = WW'(WORDS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SCAN = 4'd1;
	localparam logic [3:0] S_ARD  = 4'd2;
	localparam logic [3:0] S_ACHK = 4'd3;
	localparam logic [3:0] S_DISP = 4'd4;
	localparam logic [3:0] S_REGW = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_ADD  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_FRD  = 4'd9;
	localparam logic [3:0] S_FCHK = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;

	function automatic logic [RAW-1:0] word_addr(input logic [EW-1:0] e,
		input logic [WW-1:0] w);
		return RAW'(RAW'(e) * RAW'(WORDS) + RAW'(w));
	endfunction

	logic [3:0]           state_q;
	req_t                 req_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;
	logic [EW-1:0]        k_q;
	logic [WW-1:0]        w_q;
	logic [EW-1:0]        sel_q;
	logic                 hit_q;
	logic                 free_q;
	logic                 best_q;
	logic [WW-1:0]        best_w_q;
	logic [5:0]           best_bit_q;
	logic [WORD_W-1:0]    best_word_q;
	logic [ADDR_BITS-1:0] best_base_q;
	logic [IW-1:0]        idx_q;
	logic [PW-1:0]        prod_q;

	logic                 ent_valid_q [NUM_SLABS];
	logic [ADDR_BITS-1:0] ent_base_q  [NUM_SLABS];
	logic [SIZE_W-1:0]    ent_size_q  [NUM_SLABS];
	logic [CNT_W-1:0]     ent_total_q [NUM_SLABS];
	logic [KIND_W-1:0]    ent_kind_q  [NUM_SLABS];
	logic [CNT_W-1:0]     ent_cnt_q   [NUM_SLABS];

	logic [EW-1:0]        ei;
	logic                 e_valid;
	logic [ADDR_BITS-1:0] e_base;
	logic [SIZE_W-1:0]    e_size;
	logic [CNT_W-1:0]     e_total;
	logic [KIND_W-1:0]    e_kind;
	logic [CNT_W-1:0]     e_cnt;
	logic [CNT_W-1:0]     sat_total;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 cand;

	logic                 ram_we;
	logic [RAW-1:0]       ram_addr;
	logic [WORD_W-1:0]    ram_wdata;
	logic [WORD_W-1:0]    ram_rdata;
	logic [WORD_W-1:0]    fill;

	logic                 div_start;
	logic                 div_done;
	logic [ADDR_BITS-1:0] quot;

	assign ei = (state_q == S_SCAN || state_q == S_ARD || state_q == S_ACHK) ? k_q : sel_q;
	assign e_valid = ent_valid_q[ei];
	assign e_base  = ent_base_q[ei];
	assign e_size  = ent_size_q[ei];
	assign e_total = ent_total_q[ei];
	assign e_kind  = ent_kind_q[ei];
	assign e_cnt   = ent_cnt_q[ei];

	assign sat_total = (32'(req_q.slot_total) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS)
		: req_q.slot_total;
	assign cnt_inc = (e_cnt != COUNT_MAX) ? CNT_W'(e_cnt + 1'b1) : e_cnt;
	assign cand = e_valid && e_size == req_q.slot_bytes && e_kind == req_q.alloc_kind
		&& e_cnt != '0 && (!best_q || e_base < best_base_q);

	always_comb begin
		int lo;
		lo = 32'(w_q) * WORD_W;
		if (32'(e_total) >= lo + WORD_W) begin
			fill = '1;
		end else if (32'(e_total) > lo) begin
			fill = ~({WORD_W{1'b1}} << (32'(e_total) - lo));
		end else begin
			fill = '0;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = word_addr(sel_q, WW'(idx_q >> 6));
		ram_wdata = ram_rdata | (64'd1 << idx_q[5:0]);
		case (state_q)
			S_ARD: begin
				ram_addr = word_addr(k_q, w_q);
			end
			S_DISP: begin
				ram_addr  = word_addr(sel_q, best_w_q);
				ram_wdata = best_word_q & ~(64'd1 << best_bit_q);
				ram_we    = req_q.operation == OP_ALLOC && best_q;
			end
			S_REGW: begin
				ram_addr  = word_addr(sel_q, w_q);
				ram_wdata = fill;
				ram_we    = 1'b1;
			end
			S_FCHK: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign div_start = state_q == S_DISP && req_q.operation == OP_FREE && hit_q
		&& req_q.slot_address >= req_q.base_addr && e_size != '0;

	sbsa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	sbsa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(ADDR_BITS'(req_q.slot_address - req_q.base_addr)),
		.divisor (e_size),
		.done    (div_done),
		.quotient(quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SLABS; i++) begin
				ent_valid_q[i] <= 1'b0;
			end
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (req_q.operation == OP_ALLOC && cand) begin
						state_q <= S_ARD;
					end else if (k_q == LAST_K) begin
						state_q <= S_DISP;
					end
				end
				S_ARD: begin
					state_q <= S_ACHK;
				end
				S_ACHK: begin
					if (ram_rdata == '0 && w_q != LAST_W) begin
						state_q <= S_ARD;
					end else if (k_q == LAST_K) begin
						state_q <= S_DISP;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_DISP: begin
					case (req_q.operation)
						OP_REGISTER: begin
							if (hit_q || free_q) begin
								state_q            <= S_REGW;
								ent_valid_q[sel_q] <= 1'b1;
							end else begin
								state_q <= S_DONE;
							end
						end
						OP_ALLOC: begin
							state_q <= best_q ? S_MUL : S_DONE;
						end
						OP_FREE: begin
							state_q <= div_start ? S_DIV : S_DONE;
						end
						default: begin
							state_q <= S_DONE;
							if (hit_q) begin
								ent_valid_q[sel_q] <= 1'b0;
							end
						end
					endcase
				end
				S_REGW: begin
					if (w_q == LAST_W) begin
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_DONE;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= (quot >= ADDR_BITS'(e_total)) ? S_DONE : S_FRD;
					end
				end
				S_FRD: begin
					state_q <= S_FCHK;
				end
				S_FCHK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				req_q  <= req;
				res_q  <= '0;
				k_q    <= '0;
				w_q    <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
				best_q <= 1'b0;
			end
			S_SCAN: begin
				w_q <= '0;
				if (req_q.operation != OP_ALLOC) begin
					if (e_valid && e_base == req_q.base_addr && !hit_q) begin
						hit_q <= 1'b1;
						sel_q <= k_q;
					end else if (!e_valid && !free_q && !hit_q) begin
						free_q <= 1'b1;
						sel_q  <= k_q;
					end
				end
				if (!(req_q.operation == OP_ALLOC && cand) && k_q != LAST_K) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_ACHK: begin
				if (ram_rdata != '0) begin
					best_q      <= 1'b1;
					sel_q       <= k_q;
					best_w_q    <= w_q;
					best_bit_q  <= lowest_set(ram_rdata);
					best_word_q <= ram_rdata;
					best_base_q <= e_base;
					idx_q       <= IW'((32'(w_q) << 6) | 32'(lowest_set(ram_rdata)));
				end
				if (ram_rdata == '0 && w_q != LAST_W) begin
					w_q <= w_q + 1'b1;
				end else if (k_q != LAST_K) begin
					k_q <= k_q + 1'b1;
				end
			end
			S_DISP: begin
				w_q <= '0;
				case (req_q.operation)
					OP_REGISTER: begin
						if (hit_q || free_q) begin
							ent_base_q[sel_q]  <= req_q.base_addr;
							ent_size_q[sel_q]  <= req_q.slot_bytes;
							ent_total_q[sel_q] <= sat_total;
							ent_kind_q[sel_q]  <= req_q.alloc_kind;
							ent_cnt_q[sel_q]   <= sat_total;
						end else begin
							res_q.status <= ST_FULL;
						end
					end
					OP_ALLOC: begin
						if (best_q) begin
							ent_cnt_q[sel_q] <= e_cnt - 1'b1;
						end else begin
							res_q.status <= ST_NO_SLOT;
						end
					end
					OP_FREE: begin
						if (!hit_q) begin
							res_q.status <= ST_UNKNOWN;
						end else if (!div_start) begin
							res_q.status <= ST_BAD_SLOT;
						end
					end
					default: begin
						if (!hit_q) begin
							res_q.status <= ST_UNKNOWN;
						end
					end
				endcase
			end
			S_REGW: begin
				w_q <= w_q + 1'b1;
			end
			S_MUL: begin
				prod_q <= PW'(idx_q) * PW'(e_size);
			end
			S_ADD: begin
				res_q.address <= ADDR_BITS'(best_base_q + ADDR_BITS'(prod_q));
			end
			S_DIV: begin
				if (div_done) begin
					if (quot >= ADDR_BITS'(e_total)) begin
						res_q.status <= ST_BAD_SLOT;
					end
					idx_q <= quot[IW-1:0];
				end
			end
			S_FCHK: begin
				ent_cnt_q[sel_q]     <= cnt_inc;
				res_q.slab_now_empty <= cnt_inc == e_total;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

@@ sv/sbsa_ram.sv @@
// ----------------------------------------------------------------------------
// sbsa_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sbsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ sv/sbsa_div.sv @@
// ----------------------------------------------------------------------------
// sbsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbsa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sbsa_pkg::ADDR_BITS-1:0] dividend,
	input  logic [sbsa_pkg::SIZE_W-1:0]    divisor,
	output logic                          done,
	output logic [sbsa_pkg::ADDR_BITS-1:0] quotient
);
	import sbsa_pkg::*;

	localparam int N  = ADDR_BITS;
	localparam int D  = SIZE_W;
	localparam int CW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [D-1:0]  rem_q;
	logic [D-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [D:0]    trial;
	logic          fits;

	assign trial = {rem_q, quo_q[N-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(N);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[N-2:0], fits};
			rem_q <= fits ? D'(trial - {1'b0, dvs_q}) : trial[D-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
